### design/tsp_pkg.sv
package tsp_pkg;

    localparam int NODE_W     = 3;
    localparam int IN_WEIGHT_W = 16;
    localparam int NUM_NODES_W = 4;
    localparam int OUT_COST_W  = 19;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    typedef struct packed {
        logic                   opcode;
        logic [NODE_W-1:0]      from_node;
        logic [NODE_W-1:0]      to_node;
        logic [IN_WEIGHT_W-1:0] weight;
        logic                   edge_absent;
    } in_item_t;

    typedef struct packed {
        logic [OUT_COST_W-1:0] tour_cost;
        logic                  no_tour;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

### design/tsp_dist_mem.sv
module tsp_dist_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 17
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### design/tsp_bitmask_dynamic_programming.sv
// Load item: written when accepted, no result. Solve with n nodes: S = (2^(n-1) - 1) * n * n
// table steps (S = 1 for one node), issued one per cycle, set by the single cost-table read port.
// The run then passes ST_FLUSH and ST_DONE; m_valid rises as the block returns to ST_IDLE, once the
// output register is free. No item is taken while a solve runs or its result waits for that register.
// Reset (aresetn, synchronous, active low) clears control and sets num_nodes to 4;
// the distance and cost memories are not cleared.
module tsp_bitmask_dynamic_programming #(
    parameter int MAX_NODES   = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tsp_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tsp_pkg::out_item_t                 m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tsp_pkg::NUM_NODES_W-1:0]    cfg_data
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CNW = NW + 1;
    localparam int DD  = MAX_NODES * MAX_NODES;
    localparam int DAW = $clog2(DD);
    localparam int CD  = MAX_NODES << MAX_NODES;
    localparam int CAW = $clog2(CD);
    localparam int EW  = WEIGHT_BITS + 1;
    localparam int CW  = NW + WEIGHT_BITS + 1;
    localparam logic [CW-1:0] COST_INF = CW'(MAX_NODES) << WEIGHT_BITS;
    localparam logic [MAX_NODES-1:0] MASK_ONE = MAX_NODES'(1);
    localparam logic [MAX_NODES-1:0] MASK_TWO = MAX_NODES'(2);

    function automatic logic [CW-1:0] edge_cost(input logic [EW-1:0] e);
        logic [CW-1:0] c;
        c = e[WEIGHT_BITS] ? COST_INF : CW'(e[WEIGHT_BITS-1:0]);
        return c;
    endfunction

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (a >= COST_INF || b >= COST_INF || s >= {1'b0, COST_INF}) begin
            return COST_INF;
        end
        return s[CW-1:0];
    endfunction

    tsp_pkg::state_t state_reg, state_next;

    logic [tsp_pkg::NUM_NODES_W-1:0] num_nodes_reg;
    logic [NW-1:0]                   n_last_reg;
    logic [MAX_NODES-1:0]            full_reg;
    logic                            single_reg;
    logic [MAX_NODES-1:0]            mask_reg;
    logic [NW-1:0]                   pos_reg;
    logic [NW-1:0]                   city_reg;

    logic                 b_vld_reg;
    logic [NW-1:0]        b_pos_reg;
    logic [MAX_NODES-1:0] b_mask_reg;
    logic                 b_first_reg;
    logic                 b_last_reg;
    logic                 b_skip_reg;
    logic                 b_edge_reg;
    logic                 b_single_reg;
    logic [CW-1:0]        best_reg;
    logic [CW-1:0]        res_reg;
    logic [CW-1:0]        cost_rd_reg;

    logic               m_valid_reg;
    tsp_pkg::out_item_t m_data_reg;

    logic [CW-1:0] cost_mem [CD];

    logic                 in_acc;
    logic                 load_we;
    logic                 start;
    logic                 issue;
    logic                 issue_done;
    logic                 out_free;
    logic [CNW-1:0]       n_clamp;
    logic [MAX_NODES-1:0] full_clamp;
    logic [MAX_NODES-1:0] next_set;
    logic [DAW-1:0]       load_addr;
    logic [EW-1:0]        load_data;
    logic [DAW-1:0]       dist_addr_a;
    logic [DAW-1:0]       dist_addr_b;
    logic [EW-1:0]        dist_rd_a;
    logic [EW-1:0]        dist_rd_b;
    logic [CAW-1:0]       cost_rd_addr;
    logic [CAW-1:0]       cost_wr_addr;
    logic [CW-1:0]        edge_a;
    logic [CW-1:0]        rest;
    logic [CW-1:0]        step_cost;
    logic [CW-1:0]        cand;
    logic [CW-1:0]        base;
    logic [CW-1:0]        best_next;
    logic                 cost_we;
    logic                 cap;

    assign s_ready   = (state_reg == tsp_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign in_acc  = s_valid && s_ready;
    assign start   = in_acc && (s_data.opcode == tsp_pkg::OP_SOLVE);
    assign load_we = in_acc && (s_data.opcode == tsp_pkg::OP_LOAD)
                     && (int'(s_data.from_node) < MAX_NODES)
                     && (int'(s_data.to_node) < MAX_NODES);
    assign load_addr = DAW'(s_data.from_node) * DAW'(MAX_NODES) + DAW'(s_data.to_node);
    assign load_data = s_data.edge_absent ? {1'b1, {WEIGHT_BITS{1'b0}}}
                                          : {1'b0, WEIGHT_BITS'(s_data.weight)};

    always_comb begin
        if (num_nodes_reg == '0) begin
            n_clamp = CNW'(1);
        end else if (int'(num_nodes_reg) > MAX_NODES) begin
            n_clamp = CNW'(MAX_NODES);
        end else begin
            n_clamp = CNW'(num_nodes_reg);
        end
        for (int i = 0; i < MAX_NODES; i++) begin
            full_clamp[i] = (i < int'(n_clamp));
        end
    end

    assign issue      = (state_reg == tsp_pkg::ST_RUN);
    assign issue_done = (city_reg == n_last_reg) && (pos_reg == n_last_reg)
                        && (mask_reg == MASK_ONE);
    assign next_set   = mask_reg | (MASK_ONE << city_reg);

    assign dist_addr_a  = DAW'(pos_reg) * DAW'(MAX_NODES) + DAW'(city_reg);
    assign dist_addr_b  = DAW'(city_reg) * DAW'(MAX_NODES);
    assign cost_rd_addr = {city_reg, next_set};
    assign cost_wr_addr = {b_pos_reg, b_mask_reg};

    tsp_dist_mem #(
        .DEPTH (DD),
        .AW    (DAW),
        .DW    (EW)
    ) u_dist_mem (
        .aclk      (aclk),
        .wr_en     (load_we),
        .wr_addr   (load_addr),
        .wr_data   (load_data),
        .rd_en     (issue),
        .rd_addr_a (dist_addr_a),
        .rd_addr_b (dist_addr_b),
        .rd_data_a (dist_rd_a),
        .rd_data_b (dist_rd_b)
    );

    // step evaluation on the registered read results
    always_comb begin
        edge_a    = edge_cost(dist_rd_a);
        rest      = b_edge_reg ? edge_cost(dist_rd_b) : cost_rd_reg;
        step_cost = b_single_reg ? edge_a : sat_add(edge_a, rest);
        cand      = b_skip_reg ? COST_INF : step_cost;
        base      = b_first_reg ? COST_INF : best_reg;
        best_next = (cand < base) ? cand : base;
    end

    assign cost_we  = b_vld_reg && b_last_reg;
    assign cap      = cost_we && (b_pos_reg == '0) && (b_mask_reg == MASK_ONE);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (issue) begin
            cost_rd_reg <= cost_mem[cost_rd_addr];
        end
        if (cost_we) begin
            cost_mem[cost_wr_addr] <= best_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tsp_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = tsp_pkg::ST_RUN;
                end
            end
            tsp_pkg::ST_RUN: begin
                if (issue_done) begin
                    state_next = tsp_pkg::ST_FLUSH;
                end
            end
            tsp_pkg::ST_FLUSH: begin
                state_next = tsp_pkg::ST_DONE;
            end
            tsp_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = tsp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tsp_pkg::ST_IDLE;
            num_nodes_reg <= tsp_pkg::NUM_NODES_W'(4);
            b_vld_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            b_vld_reg <= issue;
            if (cfg_valid) begin
                num_nodes_reg <= cfg_data;
            end
            if ((state_reg == tsp_pkg::ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_last_reg <= NW'(n_clamp - CNW'(1));
            full_reg   <= full_clamp;
            single_reg <= (n_clamp == CNW'(1));
            mask_reg   <= (n_clamp == CNW'(1)) ? MASK_ONE : (full_clamp - MASK_TWO);
            pos_reg    <= '0;
            city_reg   <= '0;
        end else if (issue) begin
            if (city_reg == n_last_reg) begin
                city_reg <= '0;
                if (pos_reg == n_last_reg) begin
                    pos_reg  <= '0;
                    mask_reg <= mask_reg - MASK_TWO;
                end else begin
                    pos_reg <= pos_reg + NW'(1);
                end
            end else begin
                city_reg <= city_reg + NW'(1);
            end
        end

        if (issue) begin
            b_pos_reg    <= pos_reg;
            b_mask_reg   <= mask_reg;
            b_first_reg  <= (city_reg == '0);
            b_last_reg   <= (city_reg == n_last_reg);
            b_skip_reg   <= mask_reg[city_reg] && !single_reg;
            b_edge_reg   <= (next_set == full_reg);
            b_single_reg <= single_reg;
        end

        if (b_vld_reg) begin
            best_reg <= best_next;
        end
        if (cap) begin
            res_reg <= best_next;
        end

        if ((state_reg == tsp_pkg::ST_DONE) && out_free) begin
            m_data_reg.no_tour   <= (res_reg >= COST_INF);
            m_data_reg.tour_cost <= (res_reg >= COST_INF) ? '0
                                    : tsp_pkg::OUT_COST_W'(res_reg);
        end
    end

endmodule

### verif/tb_tsp_bitmask_dynamic_programming.sv
`timescale 1ns / 1ps
module tb_tsp_bitmask_dynamic_programming;

    localparam int NODES_MAX   = 8;
    localparam int W_BITS      = 16;
    localparam int COST_INF    = NODES_MAX << W_BITS;
    localparam int STALL_LIMIT = 40000;
    localparam int LONG_HOLD   = 300;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    tsp_pkg::in_item_t               s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    tsp_pkg::out_item_t              m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tsp_pkg::NUM_NODES_W-1:0] cfg_data  = '0;

    tsp_bitmask_dynamic_programming #(
        .MAX_NODES  (NODES_MAX),
        .WEIGHT_BITS(W_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // graph and tour-cost state, bit W_BITS of an arc marks it absent
    logic [W_BITS:0]                 arc_tab [NODES_MAX*NODES_MAX];
    int unsigned                     path_cost [NODES_MAX << NODES_MAX];
    logic [tsp_pkg::NUM_NODES_W-1:0] node_count = tsp_pkg::NUM_NODES_W'(4);

    tsp_pkg::in_item_t  pending[$];
    tsp_pkg::out_item_t tours_due[$];
    int        errors      = 0;
    int        tours_seen  = 0;
    int        loads_sent  = 0;
    int        solves_sent = 0;
    bit        s_fire      = 1'b0;
    bit        calm        = 1'b0;

    function automatic int unsigned arc_cost(int f, int t);
        if (arc_tab[f*NODES_MAX + t][W_BITS])
            return COST_INF;
        return 32'(arc_tab[f*NODES_MAX + t][W_BITS-1:0]);
    endfunction

    function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
        if (a >= COST_INF || b >= COST_INF || a + b >= COST_INF)
            return COST_INF;
        return a + b;
    endfunction

    // Held-Karp over visited sets that contain node 0, filled from the largest set down
    function automatic tsp_pkg::out_item_t cheapest_tour();
        int                 n;
        int unsigned        full, nxt, best, rest, c, total;
        tsp_pkg::out_item_t r;
        n = (node_count == 0) ? 1 : (node_count > NODES_MAX) ? NODES_MAX : node_count;
        full = (1 << n) - 1;
        if (n == 1) begin
            total = arc_cost(0, 0);
        end else begin
            for (int m = full - 1; m >= 1; m--) begin
                if (m[0]) begin
                    for (int p = 0; p < n; p++) begin
                        best = COST_INF;
                        for (int q = 0; q < n; q++) begin
                            if (!m[q]) begin
                                nxt  = m | (1 << q);
                                rest = (nxt == full) ? arc_cost(q, 0)
                                                     : path_cost[(q << NODES_MAX) | nxt];
                                c = sat_sum(arc_cost(p, q), rest);
                                if (c < best)
                                    best = c;
                            end
                        end
                        path_cost[(p << NODES_MAX) | m] = best;
                    end
                end
            end
            total = path_cost[1];
        end
        r.no_tour   = (total >= COST_INF);
        r.tour_cost = r.no_tour ? '0 : total[tsp_pkg::OUT_COST_W-1:0];
        return r;
    endfunction

    // prediction on accepted items, result checking
    always @(posedge aclk) begin
        tsp_pkg::out_item_t want;
        if (!aresetn) begin
            node_count = tsp_pkg::NUM_NODES_W'(4);
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && s_ready;
            if (cfg_valid && cfg_ready)
                node_count = cfg_data;
            if (s_valid && s_ready) begin
                if (s_data.opcode == tsp_pkg::OP_LOAD)
                    arc_tab[s_data.from_node*NODES_MAX + s_data.to_node] =
                        s_data.edge_absent ? {1'b1, {W_BITS{1'b0}}} : {1'b0, s_data.weight};
                else
                    tours_due.push_back(cheapest_tour());
            end
            if (m_valid && m_ready) begin
                tours_seen++;
                if (tours_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual cost %0d no_tour %0b",
                             $time, m_data.tour_cost, m_data.no_tour);
                    errors++;
                end else begin
                    want = tours_due.pop_front();
                    if (m_data.tour_cost !== want.tour_cost) begin
                        $display("%0t: tour_cost expected %0d actual %0d",
                                 $time, want.tour_cost, m_data.tour_cost);
                        errors++;
                    end
                    if (m_data.no_tour !== want.no_tour) begin
                        $display("%0t: no_tour expected %0b actual %0b",
                                 $time, want.no_tour, m_data.no_tour);
                        errors++;
                    end
                end
            end
        end
    end

    // sender
    int s_gap = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (s_gap > 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (pending.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                s_gap = $urandom_range(0, 5);
                s_valid <= 1'b0;
            end else begin
                s_data  <= pending.pop_front();
                s_valid <= 1'b1;
            end
        end
    end

    // receiver, with one long hold-off so the block backs up
    int m_hold = 0;
    bit long_hold_done = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_hold > 0) begin
            m_hold--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && tours_seen == 3) begin
            long_hold_done = 1'b1;
            m_hold = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_hold = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [W_BITS-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return W_BITS'($urandom_range(0, 15));
            default: return W_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_load(int f, int t, logic [W_BITS-1:0] wt, bit gone);
        tsp_pkg::in_item_t it;
        it.opcode      = tsp_pkg::OP_LOAD;
        it.from_node   = tsp_pkg::NODE_W'(f);
        it.to_node     = tsp_pkg::NODE_W'(t);
        it.weight      = wt;
        it.edge_absent = gone;
        pending.push_back(it);
        loads_sent++;
    endtask

    task automatic queue_solve();
        tsp_pkg::in_item_t it;
        it.opcode      = tsp_pkg::OP_SOLVE;
        it.from_node   = tsp_pkg::NODE_W'($urandom_range(0, 7));
        it.to_node     = tsp_pkg::NODE_W'($urandom_range(0, 7));
        it.weight      = tsp_pkg::IN_WEIGHT_W'($urandom_range(0, 65535));
        it.edge_absent = 1'($urandom_range(0, 1));
        pending.push_back(it);
        solves_sent++;
    endtask

    // every arc among the first n nodes
    task automatic queue_graph(int n, int gone_pct);
        for (int f = 0; f < n; f++)
            for (int t = 0; t < n; t++)
                queue_load(f, t, pick_weight(), $urandom_range(0, 99) < gone_pct);
    endtask

    task automatic queue_loads(int n, int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0)
                queue_load($urandom_range(0, 7), $urandom_range(0, 7), pick_weight(),
                           $urandom_range(0, 5) == 0);
            else
                queue_load($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_weight(),
                           $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending.size() != 0 || s_valid || tours_due.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_nodes(logic [tsp_pkg::NUM_NODES_W-1:0] v);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [tsp_pkg::NUM_NODES_W-1:0] cfg_pick;
        int                              n_eff;
        int                              r;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // whole store written first, so no solve reads an unwritten arc
        queue_graph(NODES_MAX, 12);
        queue_solve();
        // node 0 cut off from the rest
        queue_load(0, 1, 0, 1);
        queue_load(0, 2, 0, 1);
        queue_load(0, 3, 0, 1);
        queue_solve();

        // single node: the self-arc of node 0 is the tour
        write_nodes(1);
        queue_solve();
        queue_load(0, 0, 0, 1);
        queue_solve();
        queue_load(0, 0, '1, 0);
        queue_solve();
        queue_load(0, 0, 0, 0);
        queue_solve();

        write_nodes(2);
        queue_load(0, 1, '1, 0);
        queue_load(1, 0, '1, 0);
        queue_solve();
        // arcs beyond the node count
        queue_load(5, 6, 0, 1);
        queue_load(7, 7, 0, 0);
        queue_solve();

        // one ring of heaviest arcs, everything else absent: largest cost
        write_nodes(8);
        for (int f = 0; f < NODES_MAX; f++)
            for (int t = 0; t < NODES_MAX; t++)
                queue_load(f, t, '1, t != (f + 1) % NODES_MAX);
        queue_solve();

        // out-of-range counts clamp
        write_nodes(0);
        queue_loads(1, 4);
        queue_solve();
        write_nodes(15);
        queue_graph(NODES_MAX, 20);
        queue_solve();

        while (loads_sent + solves_sent < 1250) begin
            r = $urandom_range(0, 15);
            cfg_pick = tsp_pkg::NUM_NODES_W'((r < 12) ? r % 7 : (r == 12) ? 7
                                             : (r == 13) ? 8 : $urandom_range(9, 15));
            n_eff = (cfg_pick == 0) ? 1 : (cfg_pick > NODES_MAX) ? NODES_MAX : cfg_pick;
            if (loads_sent + solves_sent >= 1100)
                calm = 1'b1;
            write_nodes(cfg_pick);
            for (int g = 0; g < 6; g++) begin
                if ($urandom_range(0, 5) == 0)
                    queue_graph(n_eff, $urandom_range(0, 60));
                else
                    queue_loads(n_eff, $urandom_range(1, 20));
                queue_solve();
            end
        end

        calm = 1'b1;
        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
